/* hw/rtl/tpqm_pkg.sv */
// ----------------------------------------------------------------------------
// tpqm_pkg
// Shared types, widths and constants of the three-axis pid and quad mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package tpqm_pkg;

   // field and datapath widths
   localparam int DEG_W    = 9;
   localparam int ANG_W    = 16;
   localparam int THR_W    = 11;
   localparam int MOT_W    = 11;
   localparam int GAIN_W   = 16;
   localparam int LIM_W    = 9;
   localparam int BOOST_W  = 12;
   localparam int INT_W    = 24;
   localparam int ERR_W    = 17;
   localparam int ACC_W    = 48;
   localparam int AXO_W    = 38;
   localparam int INT_FRAC = 14;
   localparam int FRAC_OUT = 28;
   localparam int LO_W     = 17;
   localparam int HI_W     = 18;
   localparam int CSR_IDX_W = 3;

   // shared multiplier operand widths
   localparam int MUL_A_W = 18;
   localparam int MUL_B_W = 17;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // fixed constants
   localparam logic signed [MUL_B_W-1:0] DEG2RAD_Q16 = 17'sd1144;
   localparam logic [THR_W-1:0] FLOOR_US  = 11'd1050;
   localparam logic [THR_W-1:0] FLIGHT_US = 11'd1100;
   localparam logic [THR_W-1:0] CAP_US    = 11'd1500;

   // axis and motor codes
   localparam logic [1:0] AXIS_ROLL  = 2'd0;
   localparam logic [1:0] AXIS_PITCH = 2'd1;
   localparam logic [1:0] AXIS_YAW   = 2'd2;
   localparam logic [1:0] MOTOR_FL   = 2'd0;
   localparam logic [1:0] MOTOR_FR   = 2'd1;
   localparam logic [1:0] MOTOR_RL   = 2'd2;
   localparam logic [1:0] MOTOR_RR   = 2'd3;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_KP_ROLL    = 3'd0,
      REG_KP_PITCH   = 3'd1,
      REG_KP_YAW     = 3'd2,
      REG_KI_ALL     = 3'd3,
      REG_KD_ALL     = 3'd4,
      REG_AXIS_LIMIT = 3'd5,
      REG_BOOST_GAIN = 3'd6
   } reg_index_type;

   // register reset values
   localparam logic [GAIN_W-1:0]  KP_RESET    = 16'd12800;
   localparam logic [GAIN_W-1:0]  KI_RESET    = 16'd0;
   localparam logic [GAIN_W-1:0]  KD_RESET    = 16'd0;
   localparam logic [LIM_W-1:0]   LIMIT_RESET = 9'd200;
   localparam logic [BOOST_W-1:0] BOOST_RESET = 12'd256;

   // configuration seen by the datapath
   typedef struct packed {
      logic [GAIN_W-1:0]  kp_roll;
      logic [GAIN_W-1:0]  kp_pitch;
      logic [GAIN_W-1:0]  kp_yaw;
      logic [GAIN_W-1:0]  ki_all;
      logic [GAIN_W-1:0]  kd_all;
      logic [LIM_W-1:0]   axis_limit;
      logic [BOOST_W-1:0] boost_gain;
   } cfg_type;

   // request to the shared multiplier
   typedef struct packed {
      logic               en;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   // sequencer states
   typedef enum logic [15:0] {
      ST_IDLE  = 16'h0001,
      ST_MSP   = 16'h0002,
      ST_ERR   = 16'h0004,
      ST_MKI   = 16'h0008,
      ST_IADD  = 16'h0010,
      ST_ICLP  = 16'h0020,
      ST_ISUM  = 16'h0040,
      ST_DSUB  = 16'h0080,
      ST_MBL   = 16'h0100,
      ST_MBH   = 16'h0200,
      ST_OACC  = 16'h0400,
      ST_OCLP  = 16'h0800,
      ST_MLOAD = 16'h1000,
      ST_MADD  = 16'h2000,
      ST_MFIN  = 16'h4000,
      ST_POST  = 16'h8000
   } state_type;

   // per motor trim in us
   function automatic logic [6:0] mix_trim(input logic [1:0] motor);
      logic [6:0] trim;
      case (motor)
         MOTOR_FL: trim = 7'd118;
         MOTOR_FR: trim = 7'd4;
         MOTOR_RL: trim = 7'd0;
         default:  trim = 7'd1;
      endcase
      return trim;
   endfunction

   // mixer sign: high when the axis term is subtracted for that motor
   function automatic logic mix_negate(input logic [1:0] motor, input logic [1:0] axis);
      logic [2:0] mask;
      case (motor)
         MOTOR_FL: mask = 3'b100;
         MOTOR_FR: mask = 3'b001;
         MOTOR_RL: mask = 3'b111;
         default:  mask = 3'b010;
      endcase
      return (axis == AXIS_YAW) ? mask[2] : ((axis == AXIS_PITCH) ? mask[1] : mask[0]);
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/tpqm_csr.sv */
// ----------------------------------------------------------------------------
// tpqm_csr
// Configuration registers: gains, axis limit and boost, written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module tpqm_csr
   import tpqm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [GAIN_W-1:0]    csr_wdata,
   output      cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_KP_ROLL:    cfg_in.kp_roll    = csr_wdata;
            REG_KP_PITCH:   cfg_in.kp_pitch   = csr_wdata;
            REG_KP_YAW:     cfg_in.kp_yaw     = csr_wdata;
            REG_KI_ALL:     cfg_in.ki_all     = csr_wdata;
            REG_KD_ALL:     cfg_in.kd_all     = csr_wdata;
            REG_AXIS_LIMIT: cfg_in.axis_limit = csr_wdata[LIM_W-1:0];
            REG_BOOST_GAIN: cfg_in.boost_gain = csr_wdata[BOOST_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // register bank
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp_roll    <= KP_RESET;
         cfg_ff.kp_pitch   <= KP_RESET;
         cfg_ff.kp_yaw     <= KP_RESET;
         cfg_ff.ki_all     <= KI_RESET;
         cfg_ff.kd_all     <= KD_RESET;
         cfg_ff.axis_limit <= LIMIT_RESET;
         cfg_ff.boost_gain <= BOOST_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* hw/rtl/tpqm_mul.sv */
// ----------------------------------------------------------------------------
// tpqm_mul
// Shared signed multiplier, 18 by 17 bits, with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module tpqm_mul
   import tpqm_pkg::*;
(
   input  wire logic                      clock,
   input  wire mul_req_type               mul_req,
   output      logic signed [MUL_P_W-1:0] prod
);

   logic signed [MUL_A_W-1:0] op_a;
   logic signed [MUL_B_W-1:0] op_b;
   logic signed [MUL_P_W-1:0] prod_in;
   logic signed [MUL_P_W-1:0] prod_ff;

   // signed product, extended to the full product width
   assign op_a    = $signed(mul_req.a);
   assign op_b    = $signed(mul_req.b);
   assign prod_in = MUL_P_W'(op_a) * MUL_P_W'(op_b);

   // product register, loaded only when the sequencer asks
   always_ff @(posedge clock) begin
      if (mul_req.en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

/* hw/rtl/three_axis_pid_quad_mixer_core.sv */
// one item at a time: the next input transfer is taken only once the previous
// item has been handed to the output register and the sequencer is idle again.
// the sequencer takes 11 steps per axis through the one shared
// multiplier and accumulator, then 5 steps per motor for mixing and limiting.
// a finished result waits in the output register while the next item is taken.
// synchronous reset clears gains to defaults, integrals and last angles to zero.
// ----------------------------------------------------------------------------
// three_axis_pid_quad_mixer_core
// Three-axis pid attitude controller with quadcopter motor mixer, built as a
// small sequencer around a shared multiplier and an accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module three_axis_pid_quad_mixer_core
   import tpqm_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // input channel
   input  wire logic                    req_valid,
   output      logic                    req_stall,
   input  wire logic signed [DEG_W-1:0] req_target_roll_deg,
   input  wire logic signed [DEG_W-1:0] req_target_pitch_deg,
   input  wire logic signed [DEG_W-1:0] req_target_yaw_deg,
   input  wire logic signed [ANG_W-1:0] req_angle_roll,
   input  wire logic signed [ANG_W-1:0] req_angle_pitch,
   input  wire logic signed [ANG_W-1:0] req_angle_yaw,
   input  wire logic [THR_W-1:0]        req_throttle_us,
   // result channel
   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   output      logic [MOT_W-1:0]        rsp_motor_front_left,
   output      logic [MOT_W-1:0]        rsp_motor_front_right,
   output      logic [MOT_W-1:0]        rsp_motor_rear_left,
   output      logic [MOT_W-1:0]        rsp_motor_rear_right,
   // configuration port
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [GAIN_W-1:0]       csr_wdata
);

   localparam int MW = 14;
   localparam logic signed [ACC_W-1:0] TRUNC_BIAS = ACC_W'((64'd1 << FRAC_OUT) - 64'd1);
   localparam logic signed [MW-1:0] FLOOR_S = $signed(MW'(FLOOR_US));
   localparam logic signed [MW-1:0] CAP_S   = $signed(MW'(CAP_US));

   cfg_type                   cfg;
   mul_req_type               mul_req;
   logic signed [MUL_P_W-1:0] prod;

   // sequencer and datapath registers
   state_type                 state_ff, state_in;
   logic [1:0]                axis_ff, axis_in;
   logic [1:0]                term_ff, term_in;
   logic [1:0]                motor_ff, motor_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [ERR_W-1:0]   e_ff, e_in;
   logic signed [ERR_W-1:0]   diff_ff, diff_in;
   logic [HI_W-1:0]           shi_ff, shi_in;
   logic signed [DEG_W-1:0]   deg_ff [3];
   logic signed [DEG_W-1:0]   deg_in [3];
   logic signed [ANG_W-1:0]   ang_ff [3];
   logic signed [ANG_W-1:0]   ang_in [3];
   logic [THR_W-1:0]          thr_ff, thr_in;
   logic signed [INT_W-1:0]   integ_ff [3];
   logic signed [INT_W-1:0]   integ_in [3];
   logic signed [ANG_W-1:0]   last_ff [3];
   logic signed [ANG_W-1:0]   last_in [3];
   logic signed [AXO_W-1:0]   axo_ff [3];
   logic signed [AXO_W-1:0]   axo_in [3];
   logic [MOT_W-1:0]          mot_ff [4];
   logic [MOT_W-1:0]          mot_in [4];
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [MOT_W-1:0]          rsp_fl_ff, rsp_fl_in;
   logic [MOT_W-1:0]          rsp_fr_ff, rsp_fr_in;
   logic [MOT_W-1:0]          rsp_rl_ff, rsp_rl_in;
   logic [MOT_W-1:0]          rsp_rr_ff, rsp_rr_in;

   // datapath helper signals
   logic                      req_xfer;
   logic                      rsp_xfer;
   logic [GAIN_W-1:0]         kp_sel;
   logic signed [19:0]        sp_sum;
   logic signed [ERR_W-2:0]   spq;
   logic signed [MUL_P_W-1:0] ki_rnd;
   logic signed [MUL_P_W-7:0] ki_term;
   logic signed [ACC_W-1:0]   ilim;
   logic signed [ACC_W-1:0]   olim;
   logic signed [ACC_W-1:0]   iclamp;
   logic signed [ACC_W-1:0]   oclamp;
   logic signed [ACC_W-1:0]   acc_x2;
   logic signed [ACC_W-1:0]   mix_term;
   logic [THR_W:0]            base_us;
   logic signed [ACC_W-1:0]   trunc_sum;
   logic signed [MW-1:0]      mot_raw;
   logic signed [MW-1:0]      mot_lim;

   // configuration registers
   tpqm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // shared multiplier
   tpqm_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod    (prod)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;

   // proportional gain of the current axis
   always_comb begin
      case (axis_ff)
         AXIS_ROLL:  kp_sel = cfg.kp_roll;
         AXIS_PITCH: kp_sel = cfg.kp_pitch;
         default:    kp_sel = cfg.kp_yaw;
      endcase
   end

   // set point rounding and integral term rounding
   assign sp_sum  = $signed(prod[19:0]) + 20'sd8;
   assign spq     = $signed(sp_sum[19:4]);
   assign ki_rnd  = prod + MUL_P_W'(32);
   assign ki_term = $signed(ki_rnd[MUL_P_W-1:6]);

   // clamp limits
   assign ilim = $signed(ACC_W'({cfg.axis_limit, {INT_FRAC{1'b0}}}));
   assign olim = $signed(ACC_W'({cfg.axis_limit, {FRAC_OUT{1'b0}}}));

   // integral clamp, symmetric
   always_comb begin
      if (acc_ff > ilim) begin
         iclamp = ilim;
      end else if (acc_ff < -ilim) begin
         iclamp = -ilim;
      end else begin
         iclamp = acc_ff;
      end
   end

   // output clamp: below minus half the limit snaps to minus the limit
   assign acc_x2 = acc_ff <<< 1;
   always_comb begin
      if (acc_ff > olim) begin
         oclamp = olim;
      end else if (acc_x2 < -olim) begin
         oclamp = -olim;
      end else begin
         oclamp = acc_ff;
      end
   end

   // mixer operands
   assign mix_term = ACC_W'(axo_ff[term_ff]);
   assign base_us  = {1'b0, thr_ff} + (THR_W + 1)'(mix_trim(motor_ff));

   // truncation toward zero to whole us, then floor, pass-through, cap, zero clamp
   assign trunc_sum = acc_ff + (acc_ff[ACC_W-1] ? TRUNC_BIAS : '0);
   assign mot_raw   = $signed(trunc_sum[FRAC_OUT+MW-1:FRAC_OUT]);
   always_comb begin
      mot_lim = mot_raw;
      if ((thr_ff > FLIGHT_US) && (mot_lim < FLOOR_S)) begin
         mot_lim = FLOOR_S;
      end
      if (thr_ff < FLOOR_US) begin
         mot_lim = $signed(MW'(thr_ff));
      end
      if (mot_lim > CAP_S) begin
         mot_lim = CAP_S;
      end
      if (mot_lim < 0) begin
         mot_lim = '0;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      term_in      = term_ff;
      motor_in     = motor_ff;
      acc_in       = acc_ff;
      e_in         = e_ff;
      diff_in      = diff_ff;
      shi_in       = shi_ff;
      deg_in       = deg_ff;
      ang_in       = ang_ff;
      thr_in       = thr_ff;
      integ_in     = integ_ff;
      last_in      = last_ff;
      axo_in       = axo_ff;
      mot_in       = mot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_xfer;
      rsp_fl_in    = rsp_fl_ff;
      rsp_fr_in    = rsp_fr_ff;
      rsp_rl_in    = rsp_rl_ff;
      rsp_rr_in    = rsp_rr_ff;
      mul_req      = '0;

      unique case (state_ff)
         // take a new item
         ST_IDLE: begin
            if (req_xfer) begin
               deg_in[AXIS_ROLL]  = req_target_roll_deg;
               deg_in[AXIS_PITCH] = req_target_pitch_deg;
               deg_in[AXIS_YAW]   = req_target_yaw_deg;
               ang_in[AXIS_ROLL]  = req_angle_roll;
               ang_in[AXIS_PITCH] = req_angle_pitch;
               ang_in[AXIS_YAW]   = req_angle_yaw;
               thr_in             = req_throttle_us;
               axis_in            = AXIS_ROLL;
               state_in           = ST_MSP;
            end
         end
         // degrees to radians, measurement derivative
         ST_MSP: begin
            mul_req.en       = 1'b1;
            mul_req.a        = MUL_A_W'(deg_ff[axis_ff]);
            mul_req.b        = DEG2RAD_Q16;
            diff_in          = ERR_W'(ang_ff[axis_ff]) - ERR_W'(last_ff[axis_ff]);
            last_in[axis_ff] = ang_ff[axis_ff];
            state_in         = ST_ERR;
         end
         // error against the measurement
         ST_ERR: begin
            e_in     = ERR_W'(spq) - ERR_W'(ang_ff[axis_ff]);
            state_in = ST_MKI;
         end
         // integral gain times error
         ST_MKI: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'(e_ff);
            mul_req.b  = {1'b0, cfg.ki_all};
            state_in   = ST_IADD;
         end
         // accumulate integral, start proportional product
         ST_IADD: begin
            acc_in     = ACC_W'(integ_ff[axis_ff]) + ACC_W'(ki_term);
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'(e_ff);
            mul_req.b  = {1'b0, kp_sel};
            state_in   = ST_ICLP;
         end
         // clamp and store integral, start derivative product
         ST_ICLP: begin
            integ_in[axis_ff] = iclamp[INT_W-1:0];
            acc_in            = ACC_W'(prod);
            mul_req.en        = 1'b1;
            mul_req.a         = MUL_A_W'(diff_ff);
            mul_req.b         = {1'b0, cfg.kd_all};
            state_in          = ST_ISUM;
         end
         // add integral in the sum scale
         ST_ISUM: begin
            acc_in   = acc_ff + (ACC_W'(integ_ff[axis_ff]) <<< 6);
            state_in = ST_DSUB;
         end
         // subtract derivative
         ST_DSUB: begin
            acc_in   = acc_ff - ACC_W'(prod);
            state_in = ST_MBL;
         end
         // boost, low half of the sum
         ST_MBL: begin
            mul_req.en = 1'b1;
            mul_req.a  = {1'b0, acc_ff[LO_W-1:0]};
            mul_req.b  = {{(MUL_B_W-BOOST_W){1'b0}}, cfg.boost_gain};
            shi_in     = acc_ff[LO_W+HI_W-1:LO_W];
            state_in   = ST_MBH;
         end
         // boost, high half of the sum
         ST_MBH: begin
            acc_in     = ACC_W'(prod);
            mul_req.en = 1'b1;
            mul_req.a  = shi_ff;
            mul_req.b  = {{(MUL_B_W-BOOST_W){1'b0}}, cfg.boost_gain};
            state_in   = ST_OACC;
         end
         // combine the two halves
         ST_OACC: begin
            acc_in   = acc_ff + (ACC_W'(prod) <<< LO_W);
            state_in = ST_OCLP;
         end
         // clamp axis output, next axis or mixing
         ST_OCLP: begin
            axo_in[axis_ff] = oclamp[AXO_W-1:0];
            if (axis_ff == AXIS_YAW) begin
               motor_in = MOTOR_FL;
               state_in = ST_MLOAD;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_MSP;
            end
         end
         // throttle plus trim
         ST_MLOAD: begin
            acc_in   = $signed(ACC_W'({base_us, {FRAC_OUT{1'b0}}}));
            term_in  = AXIS_ROLL;
            state_in = ST_MADD;
         end
         // add or subtract one axis output
         ST_MADD: begin
            if (mix_negate(motor_ff, term_ff)) begin
               acc_in = acc_ff - mix_term;
            end else begin
               acc_in = acc_ff + mix_term;
            end
            if (term_ff == AXIS_YAW) begin
               state_in = ST_MFIN;
            end else begin
               term_in = term_ff + 2'd1;
            end
         end
         // limit one motor
         ST_MFIN: begin
            mot_in[motor_ff] = mot_lim[MOT_W-1:0];
            if (motor_ff == MOTOR_RR) begin
               state_in = ST_POST;
            end else begin
               motor_in = motor_ff + 2'd1;
               state_in = ST_MLOAD;
            end
         end
         // hand the result to the output register once it is free
         ST_POST: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_fl_in    = mot_ff[MOTOR_FL];
               rsp_fr_in    = mot_ff[MOTOR_FR];
               rsp_rl_in    = mot_ff[MOTOR_RL];
               rsp_rr_in    = mot_ff[MOTOR_RR];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state and controller memory
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= AXIS_ROLL;
         term_ff      <= AXIS_ROLL;
         motor_ff     <= MOTOR_FL;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            integ_ff[i] <= '0;
            last_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         term_ff      <= term_in;
         motor_ff     <= motor_in;
         rsp_valid_ff <= rsp_valid_in;
         integ_ff     <= integ_in;
         last_ff      <= last_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      e_ff      <= e_in;
      diff_ff   <= diff_in;
      shi_ff    <= shi_in;
      deg_ff    <= deg_in;
      ang_ff    <= ang_in;
      thr_ff    <= thr_in;
      axo_ff    <= axo_in;
      mot_ff    <= mot_in;
      rsp_fl_ff <= rsp_fl_in;
      rsp_fr_ff <= rsp_fr_in;
      rsp_rl_ff <= rsp_rl_in;
      rsp_rr_ff <= rsp_rr_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_motor_front_left  = rsp_fl_ff;
   assign rsp_motor_front_right = rsp_fr_ff;
   assign rsp_motor_rear_left   = rsp_rl_ff;
   assign rsp_motor_rear_right  = rsp_rr_ff;

`ifndef NO_ASSERTIONS
   // an input transfer starts the sequencer, which then holds off new items
   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> req_stall)
      else $error("block ready right after an input transfer");

   // a new result appears only out of the hand-off step
   a_valid_from_post: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_POST))
      else $error("result valid raised outside the hand-off step");

   // every delivered pulse respects the cap
   a_pulse_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_fl_ff <= CAP_US) && (rsp_fr_ff <= CAP_US) &&
                       (rsp_rl_ff <= CAP_US) && (rsp_rr_ff <= CAP_US))
      else $error("motor pulse above cap");
`endif

endmodule

`default_nettype wire
